// ===== rtl/bfm3_pkg.sv =====
`default_nettype none

package bfm3_pkg;

  // Filter geometry. The filter size is taken to be a power of two, so that
  // the modulo on a finished hash is a plain mask of its low bits.
  localparam int FILTER_BITS = 8192;
  localparam int HASH_COUNT  = 3;
  localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int BIT_W       = $clog2(FILTER_BITS);
  localparam int LANE_W      = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int IDX_W = 10;

  // Hash constants.
  localparam logic [31:0] SEED_BASE = 32'hbc9f1d34;
  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] MIX_ADD   = 32'he6546b64;
  localparam logic [31:0] FIN_M1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2    = 32'hc2b2ae35;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Result kinds.
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       key_byte;
    logic             last_byte;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       write_value;
  } in_beat_t;

  typedef struct packed {
    logic       result_kind;
    logic       present;
    logic [7:0] read_value;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_CLEAR_STEP,
    DP_STORE_WR,
    DP_STORE_RD,
    DP_EMIT_READ,
    DP_ABSORB,
    DP_SCR_A,
    DP_SCR_B,
    DP_ROUND,
    DP_FIN_A,
    DP_FIN_B,
    DP_ADDR,
    DP_BIT_RD,
    DP_BIT_UPD,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [LANE_W-1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;    // clearing pass is at the final store byte
    logic block_fill;  // the byte being absorbed completes a block
    logic tail;        // a partial block is pending
    logic last_byte;   // captured beat ends its key
  } dp_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bfm3_mem.sv =====
`default_nettype none

module bfm3_mem (
  input  wire logic              clk,
  input  wire bfm3_pkg::mem_req_t req,
  output logic [7:0]             rdata
);
  import bfm3_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

`default_nettype wire

// ===== rtl/bfm3_dp.sv =====
`default_nettype none

module bfm3_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bfm3_pkg::in_beat_t in_beat,
  input  wire bfm3_pkg::dp_cmd_t  cmd,
  output bfm3_pkg::dp_stat_t      stat,
  output bfm3_pkg::mem_req_t      mem_req,
  input  wire logic [7:0]         mem_rdata,
  output logic                    out_strobe,
  output bfm3_pkg::out_beat_t     out_beat
);
  import bfm3_pkg::*;

  in_beat_t          beat_r;
  logic [31:0]       acc_r [HASH_COUNT];
  logic [31:0]       bw_r;
  logic [31:0]       len_r;
  logic [31:0]       p_r;
  logic [31:0]       k_r;
  logic [BIT_W-1:0]  bit_r;
  logic              all_r;
  logic [ADDR_W-1:0] clr_r;
  logic              out_strobe_r;
  out_beat_t         out_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] tail_k;
  logic [31:0] fin_in;
  logic        idx_ok;
  logic [7:0]  mask;

  assign idx_ok = {1'b0, beat_r.byte_index} < (IDX_W + 1)'(STORE_BYTES);
  assign tail_k = stat.tail ? k_r : 32'd0;
  assign fin_in = acc_r[cmd.lane] ^ tail_k ^ len_r;
  assign mask   = 8'd1 << bit_r[2:0];

  assign stat.clr_last   = clr_r == ADDR_W'(STORE_BYTES - 1);
  assign stat.block_fill = len_r[1:0] == 2'b11;
  assign stat.tail       = len_r[1:0] != 2'b00;
  assign stat.last_byte  = beat_r.last_byte;

  // One shared multiplier, low 32 bits of the product.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      DP_SCR_A: begin
        mul_a = bw_r;
        mul_b = MIX_C1;
      end
      DP_SCR_B: begin
        mul_a = rotl32(p_r, 15);
        mul_b = MIX_C2;
      end
      DP_FIN_A: begin
        mul_a = fin_in ^ (fin_in >> 16);
        mul_b = FIN_M1;
      end
      DP_FIN_B: begin
        mul_a = p_r ^ (p_r >> 13);
        mul_b = FIN_M2;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = ADDR_W'(beat_r.byte_index);
    mem_req.wdata = beat_r.write_value;
    case (cmd.op)
      DP_CLEAR_STEP: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = 8'd0;
      end
      DP_STORE_WR: begin
        mem_req.we = idx_ok;
      end
      DP_BIT_RD: begin
        mem_req.addr = ADDR_W'(bit_r >> 3);
      end
      DP_BIT_UPD: begin
        mem_req.addr  = ADDR_W'(bit_r >> 3);
        mem_req.we    = beat_r.op == OP_INSERT;
        mem_req.wdata = mem_rdata | mask;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HASH_COUNT; i++) begin
        acc_r[i] <= SEED_BASE + 32'(i);
      end
      bw_r         <= 32'd0;
      len_r        <= 32'd0;
      all_r        <= 1'b1;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (cmd.op)
        DP_CAPTURE: begin
          beat_r <= in_beat;
        end
        DP_CLEAR_STEP: begin
          clr_r <= clr_r + ADDR_W'(1);
        end
        DP_EMIT_READ: begin
          out_strobe_r <= 1'b1;
          out_r        <= '{result_kind: KIND_READ, present: 1'b0,
                            read_value: idx_ok ? mem_rdata : 8'd0};
        end
        DP_ABSORB: begin
          bw_r  <= bw_r | (32'(beat_r.key_byte) << {len_r[1:0], 3'b000});
          len_r <= len_r + 32'd1;
        end
        DP_SCR_A: begin
          p_r <= prod;
        end
        DP_SCR_B: begin
          k_r <= prod;
        end
        DP_ROUND: begin
          // All lanes take the same scrambled block in one step.
          for (int i = 0; i < HASH_COUNT; i++) begin
            acc_r[i] <= (rotl32(acc_r[i] ^ k_r, 13) << 2)
                        + rotl32(acc_r[i] ^ k_r, 13) + MIX_ADD;
          end
          bw_r <= 32'd0;
        end
        DP_FIN_A, DP_FIN_B: begin
          p_r <= prod;
        end
        DP_ADDR: begin
          bit_r <= BIT_W'(p_r ^ (p_r >> 16));
        end
        DP_BIT_UPD: begin
          all_r <= all_r & mem_rdata[bit_r[2:0]];
        end
        DP_FINISH: begin
          for (int i = 0; i < HASH_COUNT; i++) begin
            acc_r[i] <= SEED_BASE + 32'(i);
          end
          bw_r         <= 32'd0;
          len_r        <= 32'd0;
          all_r        <= 1'b1;
          out_strobe_r <= beat_r.op == OP_QUERY;
          out_r        <= '{result_kind: KIND_QUERY, present: all_r,
                            read_value: 8'd0};
        end
        default: begin
          out_strobe_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_r;

endmodule

`default_nettype wire

// ===== rtl/bfm3_ctrl.sv =====
`default_nettype none

module bfm3_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_op,
  input  wire bfm3_pkg::dp_stat_t stat,
  output bfm3_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import bfm3_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_READ_OUT,
    S_ABSORB,
    S_SCR_A,
    S_SCR_B,
    S_ROUND,
    S_FIN_A,
    S_FIN_B,
    S_ADDR,
    S_BIT_RD,
    S_BIT_UPD,
    S_FINISH
  } state_e;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(HASH_COUNT - 1);

  state_e            state_r;
  state_e            state_nxt;
  logic [LANE_W-1:0] lane_r;
  logic [LANE_W-1:0] lane_nxt;

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    cmd.op    = DP_NOP;
    cmd.lane  = lane_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR_STEP;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_CAPTURE;
          case (in_op)
            OP_WRITE: state_nxt = S_WRITE;
            OP_READ:  state_nxt = S_READ;
            default:  state_nxt = S_ABSORB;
          endcase
        end
      end
      S_WRITE: begin
        cmd.op    = DP_STORE_WR;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        cmd.op    = DP_STORE_RD;
        state_nxt = S_READ_OUT;
      end
      S_READ_OUT: begin
        cmd.op    = DP_EMIT_READ;
        state_nxt = S_IDLE;
      end
      S_ABSORB: begin
        cmd.op    = DP_ABSORB;
        state_nxt = (stat.block_fill || stat.last_byte) ? S_SCR_A : S_IDLE;
      end
      S_SCR_A: begin
        cmd.op    = DP_SCR_A;
        state_nxt = S_SCR_B;
      end
      S_SCR_B: begin
        // A partial block here is the tail, which goes straight to finishing.
        cmd.op    = DP_SCR_B;
        state_nxt = stat.tail ? S_FIN_A : S_ROUND;
      end
      S_ROUND: begin
        cmd.op    = DP_ROUND;
        state_nxt = stat.last_byte ? S_FIN_A : S_IDLE;
      end
      S_FIN_A: begin
        cmd.op    = DP_FIN_A;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        cmd.op    = DP_FIN_B;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.op    = DP_ADDR;
        state_nxt = S_BIT_RD;
      end
      S_BIT_RD: begin
        cmd.op    = DP_BIT_RD;
        state_nxt = S_BIT_UPD;
      end
      S_BIT_UPD: begin
        cmd.op = DP_BIT_UPD;
        if (lane_r == LAST_LANE) begin
          lane_nxt  = '0;
          state_nxt = S_FINISH;
        end else begin
          lane_nxt  = lane_r + LANE_W'(1);
          state_nxt = S_FIN_A;
        end
      end
      S_FINISH: begin
        cmd.op    = DP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not make the block busy");

  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, lane_r} < (LANE_W + 1)'(HASH_COUNT))
    else $error("lane index beyond hash count");

  a_idle_lane: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> lane_r == '0)
    else $error("lane index not rewound between keys");

  a_lane_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BIT_UPD && lane_r != LAST_LANE |=>
      state_r == S_FIN_A && lane_r == $past(lane_r) + LANE_W'(1))
    else $error("lane sequence skipped or repeated");
`endif

endmodule

`default_nettype wire

// ===== rtl/bloom_filter_murmur3_three_hash.sv =====
`default_nettype none

// Bloom filter with three MurmurHash3-32 lanes over an 8192-bit store held as
// 1024 bytes in a single-port memory. After reset the block runs a clearing
// pass, one store byte per cycle, with busy high; no beat is taken until it
// ends. A beat is accepted at a rising edge where start is high and busy is
// low; busy then stays high while the beat is worked on, so the block handles
// one beat at a time. Results carry no back-pressure: each one is shown on
// out_beat for exactly one cycle with out_strobe high, and the receiver must
// take it then. A store write makes one store access; a store read reads the
// store and then strobes its result in the same cycle as busy falls. A key
// byte that does not complete a 4-byte block is only absorbed; one that does
// is then scrambled by two dependent multiplications on the shared multiplier
// before the three lanes absorb it together. The final key byte adds a tail
// scramble when the key length is not a multiple of four, then for each lane
// in turn two avalanche multiplications, the bit address, a store read and a
// store update (the last two through the one memory port), and a closing
// step; the query answer strobes in the same cycle as busy falls. Insert and
// query bytes feed the same hash state; the op of the beat that carries
// last_byte decides whether the key is inserted or queried, and store writes
// and reads between key bytes leave the key in progress untouched.
module bloom_filter_murmur3_three_hash (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bfm3_pkg::in_beat_t  in_beat,
  output logic                     out_strobe,
  output bfm3_pkg::out_beat_t      out_beat
);
  import bfm3_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // The controller sequences every operation; it sees only start, the op of the
  // incoming beat and the status flags of the datapath.
  bfm3_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_beat.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the captured beat, the hash lanes, the shared
  // multiplier and the result register, and drives the store port.
  bfm3_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beat    (in_beat),
    .cmd        (cmd),
    .stat       (stat),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  // The bit store itself, with registered read data.
  bfm3_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  import bfm3_pkg::*;

  // Length of the directed table, number of random beats and key shapes.
  localparam int DIR_ROWS     = 24;
  localparam int RAND_BEATS   = 750;
  localparam int MAX_KEY      = 16;
  localparam int POOL_KEYS    = 12;
  // The clearing pass after reset keeps busy high throughout. The slowest
  // beat is a last key byte that completes a block, and the sender draws a
  // gap between beats. The limit on cycles with no progress sits well above
  // all of these.
  localparam int STALL_LIMIT  = 4000;
  // After the final answer has arrived, the block may still be finishing an
  // insert, which gives no result. This covers that and any stray strobe.
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_strobe;
  out_beat_t out_beat;

  bloom_filter_murmur3_three_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_beat    (in_beat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the filter: three hash lanes, the partly filled block,
  // the byte count of the key in progress and the whole bit store.
  // ---------------------------------------------------------------------
  logic [31:0] lane_hash [HASH_COUNT];
  logic [31:0] open_block;
  logic [31:0] key_count;
  logic [7:0]  store_copy [STORE_BYTES];

  // Answers still owed by the block, oldest first.
  out_beat_t pending_answers [$];
  out_beat_t oldest_answer;
  int        fault_count  = 0;
  int        beats_sent   = 0;
  int        calm_left    = 0;
  int        stall_cycles = 0;

  // Key under construction for the random part, and a pool of keys that are
  // sent again and again so that queries find keys that were inserted.
  logic [7:0] key_buf [MAX_KEY];
  int         key_len;
  logic [7:0] pool_bytes [POOL_KEYS][MAX_KEY];
  int         pool_len [POOL_KEYS];

  // One line per mismatch, and a count of them all.
  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fault_count++;
  endtask

  // Block mixing step of MurmurHash3: multiply, rotate left by 15, multiply.
  function automatic logic [31:0] mm3_scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * MIX_C1;
    t = (t << 15) | (t >> 17);
    return t * MIX_C2;
  endfunction

  // Final avalanche applied to each lane once the key has ended.
  function automatic logic [31:0] mm3_avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FIN_M1;
    t = t ^ (t >> 13);
    t = t * FIN_M2;
    return t ^ (t >> 16);
  endfunction

  task automatic clear_key();
    for (int l = 0; l < HASH_COUNT; l++) begin
      lane_hash[l] = SEED_BASE + 32'(l);
    end
    open_block = '0;
    key_count  = '0;
  endtask

  // Moves the shadow filter on by one accepted beat and works out the answer
  // that beat owes, if any.
  task automatic filter_step(input in_beat_t b, output logic answered,
                             output out_beat_t answer);
    logic [31:0] k;
    logic [31:0] h;
    logic [31:0] tail;
    logic [31:0] bit_pos;
    logic [7:0]  mask;
    logic        all_set;
    answered = 1'b0;
    answer   = '0;
    case (b.op)
      OP_WRITE: begin
        if (int'(b.byte_index) < STORE_BYTES) begin
          store_copy[b.byte_index] = b.write_value;
        end
      end
      OP_READ: begin
        answered           = 1'b1;
        answer.result_kind = KIND_READ;
        if (int'(b.byte_index) < STORE_BYTES) begin
          answer.read_value = store_copy[b.byte_index];
        end
      end
      OP_INSERT, OP_QUERY: begin
        // Bytes fill the block little-endian; a full block is scrambled and
        // folded into every lane.
        open_block = open_block | (32'(b.key_byte) << (8 * key_count[1:0]));
        key_count  = key_count + 32'd1;
        if (key_count[1:0] == 2'd0) begin
          k = mm3_scramble(open_block);
          for (int l = 0; l < HASH_COUNT; l++) begin
            h = lane_hash[l] ^ k;
            h = (h << 13) | (h >> 19);
            lane_hash[l] = h * 32'd5 + MIX_ADD;
          end
          open_block = '0;
        end
        if (b.last_byte) begin
          // The op of the closing beat alone decides insert or query.
          tail    = (key_count[1:0] != 2'd0) ? mm3_scramble(open_block) : '0;
          all_set = 1'b1;
          for (int l = 0; l < HASH_COUNT; l++) begin
            h       = mm3_avalanche(lane_hash[l] ^ tail ^ key_count);
            bit_pos = h % 32'(FILTER_BITS);
            mask    = 8'd1 << bit_pos[2:0];
            if (b.op == OP_INSERT) begin
              store_copy[bit_pos >> 3] = store_copy[bit_pos >> 3] | mask;
            end else if ((store_copy[bit_pos >> 3] & mask) == 8'd0) begin
              all_set = 1'b0;
            end
          end
          clear_key();
          if (b.op == OP_QUERY) begin
            answered           = 1'b1;
            answer.result_kind = KIND_QUERY;
            answer.present     = all_set;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offers one beat, waits for the handshake and records what it owes. The
  // gap before the beat is drawn afresh each time, except during calm
  // stretches in which beats follow one another back to back. When there is
  // no gap, start simply stays high from the previous beat.
  task automatic push_beat(input in_beat_t b, input logic fixed,
                           input out_beat_t want);
    int        gap;
    logic      answered;
    out_beat_t answer;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    filter_step(b, answered, answer);
    if (answered) begin
      pending_answers.push_back(fixed ? want : answer);
    end
    beats_sent++;
  endtask

  // Every field random, so that the fields an op ignores toggle as well.
  function automatic in_beat_t noise_beat();
    logic [31:0] raw;
    raw = $urandom;
    return in_beat_t'(raw[$bits(in_beat_t)-1:0]);
  endfunction

  // Mostly short keys, sometimes longer ones over several full blocks.
  function automatic int draw_key_length();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(9, MAX_KEY);
    end
    return $urandom_range(1, 8);
  endfunction

  // A store write or read, now and then at the first or the last byte and
  // with an all-zero or all-one value.
  task automatic send_store_op();
    in_beat_t b;
    b    = noise_beat();
    b.op = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
    case ($urandom_range(0, 9))
      0: begin
        b.byte_index = '0;
      end
      1: begin
        b.byte_index = '1;
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      b.write_value = {8{b.write_value[0]}};
    end
    push_beat(b, 1'b0, '0);
  endtask

  // Streams key_buf as one key. Most bytes carry the closing op, some a random
  // one of insert and query; store beats are slipped in between bytes now and then.
  task automatic send_key(input logic [1:0] end_op);
    in_beat_t b;
    for (int i = 0; i < key_len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_store_op();
      end
      b           = noise_beat();
      b.key_byte  = key_buf[i];
      b.last_byte = (i == key_len - 1);
      if (i == key_len - 1 || $urandom_range(0, 4) != 0) begin
        b.op = end_op;
      end else begin
        b.op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_QUERY;
      end
      push_beat(b, 1'b0, '0);
    end
  endtask

  // Directed beats. Where fixed is set, the answer is written here; every
  // other row is checked against the shadow filter. The rows cover reads of
  // a freshly cleared store at both ends, writes and read-back of extreme
  // values, a one-byte key queried before and after its insert, a key of
  // exactly one block with no tail, and a key whose bytes mix both ops with
  // a store write and read slipped in while it is in progress.
  typedef struct packed {
    in_beat_t  beat;
    logic      fixed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{OP_READ,   8'h00, 1'b0, 10'd0,    8'h00}, 1'b1, '{KIND_READ,  1'b0, 8'h00}},
    '{'{OP_READ,   8'hff, 1'b1, 10'd1023, 8'hff}, 1'b1, '{KIND_READ,  1'b0, 8'h00}},
    '{'{OP_WRITE,  8'h00, 1'b0, 10'd0,    8'hff}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_WRITE,  8'hff, 1'b1, 10'd1023, 8'ha5}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_READ,   8'h00, 1'b0, 10'd0,    8'h00}, 1'b1, '{KIND_READ,  1'b0, 8'hff}},
    '{'{OP_READ,   8'h00, 1'b0, 10'd1023, 8'h00}, 1'b1, '{KIND_READ,  1'b0, 8'ha5}},
    '{'{OP_WRITE,  8'h00, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_READ,   8'h00, 1'b0, 10'd0,    8'h00}, 1'b1, '{KIND_READ,  1'b0, 8'h00}},
    '{'{OP_QUERY,  8'h61, 1'b1, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_INSERT, 8'h61, 1'b1, 10'h3ff,  8'hff}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'h61, 1'b1, 10'd0,    8'h00}, 1'b1, '{KIND_QUERY, 1'b1, 8'h00}},
    '{'{OP_INSERT, 8'hff, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_INSERT, 8'h00, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_INSERT, 8'hff, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_INSERT, 8'h80, 1'b1, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'hff, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'h00, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'hff, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'h80, 1'b1, 10'd0,    8'h00}, 1'b1, '{KIND_QUERY, 1'b1, 8'h00}},
    '{'{OP_INSERT, 8'h11, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_WRITE,  8'h5a, 1'b1, 10'd512,  8'h3c}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_QUERY,  8'h22, 1'b0, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}},
    '{'{OP_READ,   8'h5a, 1'b1, 10'd512,  8'h00}, 1'b1, '{KIND_READ,  1'b0, 8'h3c}},
    '{'{OP_QUERY,  8'h33, 1'b1, 10'd0,    8'h00}, 1'b0, '{KIND_QUERY, 1'b0, 8'h00}}
  };

  // Stimulus: reset, the directed table, then random keys and store beats.
  initial begin
    int pick;
    int p;
    clear_key();
    foreach (store_copy[i]) begin
      store_copy[i] = '0;
    end
    for (int q = 0; q < POOL_KEYS; q++) begin
      pool_len[q] = draw_key_length();
      for (int i = 0; i < MAX_KEY; i++) begin
        pool_bytes[q][i] = 8'($urandom);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_beat(dir_table[r].beat, dir_table[r].fixed, dir_table[r].want);
    end

    // Most of the random part is whole keys: some drawn from the pool, so
    // that queries often hit an inserted key, the rest fresh. Store beats
    // make up the remainder and also land in the middle of keys.
    while (beats_sent < DIR_ROWS + RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_store_op();
      end else begin
        if (pick < 60) begin
          p       = $urandom_range(0, POOL_KEYS - 1);
          key_len = pool_len[p];
          for (int i = 0; i < MAX_KEY; i++) begin
            key_buf[i] = pool_bytes[p][i];
          end
        end else begin
          key_len = draw_key_length();
          for (int i = 0; i < MAX_KEY; i++) begin
            key_buf[i] = 8'($urandom);
          end
        end
        send_key(($urandom_range(0, 99) < 45) ? OP_INSERT : OP_QUERY);
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Each strobed result is matched against the oldest answer still owed.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("result beat %p with no answer outstanding", out_beat));
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_beat.result_kind !== oldest_answer.result_kind) begin
          flag_mismatch($sformatf("result_kind %b, wanted %b",
                                  out_beat.result_kind, oldest_answer.result_kind));
        end
        if (out_beat.present !== oldest_answer.present) begin
          flag_mismatch($sformatf("present %b, wanted %b",
                                  out_beat.present, oldest_answer.present));
        end
        if (out_beat.read_value !== oldest_answer.read_value) begin
          flag_mismatch($sformatf("read_value %h, wanted %h",
                                  out_beat.read_value, oldest_answer.read_value));
        end
      end
    end
  end

  // Watchdog: any accepted beat or strobed result counts as progress.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
